// ===== rtl/rcc_pkg.sv =====
// Shared widths and result codes for the capped cylinder intersection core.
package rcc_pkg;

   localparam int COORD_W = 32;
   localparam int DIST_W  = 31;

   typedef enum logic [1:0] {
      PART_BOTTOM = 2'd0,
      PART_SIDE   = 2'd1,
      PART_TOP    = 2'd2
   } part_type;

endpackage

// ===== rtl/ray_capped_cylinder_intersect_core.sv =====
// Top level: ray against capped unit cylinder, fully pipelined.
//
//  channel   ports                     handshake
//  request   start, busy, req_*        taken when start && !busy
//  response  rsp_valid, rsp_*          one-cycle strobe, no backpressure
//
//  Accepts one request per cycle while busy is low.
//  The pipeline contains the 64-stage square root and the (65 + FRAC_BITS)-stage
//  dividers, both one bit per stage.
//  Synchronous reset clears all valid bits; busy is high during reset and in the
//  first cycle after it.
//  The response side cannot stall, so the pipeline never holds.
module ray_capped_cylinder_intersect_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [rcc_pkg::COORD_W-1:0]  req_origin_x,
   input  logic signed [rcc_pkg::COORD_W-1:0]  req_origin_y,
   input  logic signed [rcc_pkg::COORD_W-1:0]  req_origin_z,
   input  logic signed [rcc_pkg::COORD_W-1:0]  req_dir_x,
   input  logic signed [rcc_pkg::COORD_W-1:0]  req_dir_y,
   input  logic signed [rcc_pkg::COORD_W-1:0]  req_dir_z,
   input  logic [rcc_pkg::DIST_W-1:0]          req_max_dist,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [rcc_pkg::DIST_W-1:0]          rsp_hit_dist,
   output rcc_pkg::part_type                   rsp_part
);

   import rcc_pkg::*;

   localparam int NW  = 65 + FRAC_BITS;
   localparam int TW  = NW + 1;
   localparam int NCH = (TW + 31) / 32;
   localparam int TXW = NCH * 32;
   localparam int YW  = TXW + 33;
   localparam logic [64:0]          ONE2    = 65'd1 << (2 * FRAC_BITS);
   localparam logic signed [YW-1:0] ONE_Y   = YW'(1) << (2 * FRAC_BITS);
   localparam logic signed [33:0]   CAP_ONE = 34'sd1 << FRAC_BITS;

   typedef struct packed {
      logic               miss;
      logic signed [64:0] h;
      logic [63:0]        a;
      logic signed [31:0] oy;
      logic signed [31:0] dy;
      logic [30:0]        tmax;
   } sq_side_type;

   typedef struct packed {
      logic               miss;
      logic               dyz;
      logic signed [31:0] oy;
      logic signed [31:0] dy;
      logic [30:0]        tmax;
      logic               neg0;
      logic               neg1;
      logic               cneg0;
      logic               cneg1;
   } dv_side_type;

   // valid chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic v8_ff, v9_ff, v10_ff, v11_ff, v12_ff;
   logic busy_ff, rsp_valid_ff;

   // stage 1: input capture
   logic signed [31:0] ox1_ff, oy1_ff, oz1_ff, dx1_ff, dy1_ff, dz1_ff;
   logic [30:0]        tmax1_ff;
   // stage 2: products
   logic signed [63:0] sxx2_ff, szz2_ff, sxo2_ff, szo2_ff, oxx2_ff, ozz2_ff;
   logic signed [31:0] oy2_ff, dy2_ff;
   logic [30:0]        tmax2_ff;
   // stage 3: quadratic terms
   logic [63:0]        a3_ff;
   logic signed [64:0] h3_ff, c3_ff;
   logic signed [31:0] oy3_ff, dy3_ff;
   logic [30:0]        tmax3_ff;
   // stage 4: magnitudes
   logic [63:0]        hm4_ff, cm4_ff, a4_ff;
   logic               cneg4_ff, azero4_ff;
   logic signed [64:0] h4_ff;
   logic signed [31:0] oy4_ff, dy4_ff;
   logic [30:0]        tmax4_ff;
   // stage 5: partial products
   logic [63:0]        hll5_ff, hlh5_ff, hhh5_ff;
   logic [63:0]        all5_ff, alh5_ff, ahl5_ff, ahh5_ff;
   logic [63:0]        a5_ff;
   logic               cneg5_ff, azero5_ff;
   logic signed [64:0] h5_ff;
   logic signed [31:0] oy5_ff, dy5_ff;
   logic [30:0]        tmax5_ff;
   // stage 6: squares
   logic [127:0]       hsq6_ff, ac6_ff;
   logic [63:0]        a6_ff;
   logic               cneg6_ff, azero6_ff;
   logic signed [64:0] h6_ff;
   logic signed [31:0] oy6_ff, dy6_ff;
   logic [30:0]        tmax6_ff;
   // stage 7: discriminant
   logic [127:0]       d7_ff;
   logic [63:0]        a7_ff;
   logic               azero7_ff;
   logic signed [64:0] h7_ff;
   logic signed [31:0] oy7_ff, dy7_ff;
   logic [30:0]        tmax7_ff;

   sq_side_type        sq_in_side, sq_out_side;
   logic               sq_out_valid;
   logic [63:0]        sq_root;

   // stage 8: signed numerators
   logic signed [66:0] n0_8_ff, n1_8_ff;
   logic signed [33:0] c0_8_ff, c1_8_ff;
   logic [63:0]        a8_ff;
   logic               miss8_ff;
   logic signed [31:0] oy8_ff, dy8_ff;
   logic [30:0]        tmax8_ff;
   logic signed [66:0] hx_in, sx_in;
   logic signed [33:0] oyx_in;

   // stage 9: divider operands
   logic [3:0][NW-1:0] num9_ff;
   logic [3:0][63:0]   den9_ff;
   dv_side_type        side9_ff;
   logic [66:0]        n0m_in, n1m_in;
   logic [33:0]        c0m_in, c1m_in;
   logic [31:0]        dym_in;

   logic               dv_out_valid;
   logic [3:0][NW-1:0] dv_quot;
   logic [3:0]         dv_nz;
   dv_side_type        dv_out_side;

   // stage 10: signed distances
   logic signed [TW-1:0] t0_10_ff, t1_10_ff, tc0_10_ff, tc1_10_ff;
   logic               miss10_ff, dyz10_ff;
   logic signed [31:0] oy10_ff, dy10_ff;
   logic [30:0]        tmax10_ff;

   // stage 11: height partial products
   logic signed [64:0]   pr0_11_ff [NCH];
   logic signed [64:0]   pr1_11_ff [NCH];
   logic signed [TW-1:0] t0_11_ff, tc0_11_ff, tc1_11_ff;
   logic               miss11_ff, dyz11_ff;
   logic signed [31:0] oy11_ff;
   logic [30:0]        tmax11_ff;
   logic [TXW-1:0]     t0x_in, t1x_in;

   // stage 12: heights
   logic signed [YW-1:0] y0_12_ff, y1_12_ff;
   logic signed [TW-1:0] t0_12_ff, tc0_12_ff, tc1_12_ff;
   logic               miss12_ff, dyz12_ff;
   logic [30:0]        tmax12_ff;
   logic signed [YW-1:0] y0_in, y1_in;

   // response registers
   logic               rsp_hit_ff;
   logic [30:0]        rsp_dist_ff;
   part_type           rsp_part_ff;
   logic               hit_in;
   logic [30:0]        dist_in;
   part_type           part_in;
   logic signed [TW-1:0] tmaxx;
   logic               t0_ok, tc0_ok, tc1_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         v12_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         v1_ff        <= start & ~busy_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= sq_out_valid;
         v9_ff        <= v8_ff;
         v10_ff       <= dv_out_valid;
         v11_ff       <= v10_ff;
         v12_ff       <= v11_ff;
         rsp_valid_ff <= v12_ff;
      end
   end

   // stages 1 to 7
   always_ff @(posedge clock) begin
      ox1_ff   <= req_origin_x;
      oy1_ff   <= req_origin_y;
      oz1_ff   <= req_origin_z;
      dx1_ff   <= req_dir_x;
      dy1_ff   <= req_dir_y;
      dz1_ff   <= req_dir_z;
      tmax1_ff <= req_max_dist;

      sxx2_ff  <= 64'(dx1_ff) * 64'(dx1_ff);
      szz2_ff  <= 64'(dz1_ff) * 64'(dz1_ff);
      sxo2_ff  <= 64'(dx1_ff) * 64'(ox1_ff);
      szo2_ff  <= 64'(dz1_ff) * 64'(oz1_ff);
      oxx2_ff  <= 64'(ox1_ff) * 64'(ox1_ff);
      ozz2_ff  <= 64'(oz1_ff) * 64'(oz1_ff);
      oy2_ff   <= oy1_ff;
      dy2_ff   <= dy1_ff;
      tmax2_ff <= tmax1_ff;

      a3_ff    <= sxx2_ff + szz2_ff;
      h3_ff    <= {sxo2_ff[63], sxo2_ff} + {szo2_ff[63], szo2_ff};
      c3_ff    <= $signed({1'b0, oxx2_ff} + {1'b0, ozz2_ff} - ONE2);
      oy3_ff   <= oy2_ff;
      dy3_ff   <= dy2_ff;
      tmax3_ff <= tmax2_ff;

      hm4_ff    <= h3_ff[64] ? 64'(-h3_ff) : h3_ff[63:0];
      cm4_ff    <= c3_ff[64] ? 64'(-c3_ff) : c3_ff[63:0];
      cneg4_ff  <= c3_ff[64];
      azero4_ff <= (a3_ff == 64'd0);
      a4_ff     <= a3_ff;
      h4_ff     <= h3_ff;
      oy4_ff    <= oy3_ff;
      dy4_ff    <= dy3_ff;
      tmax4_ff  <= tmax3_ff;

      hll5_ff   <= 64'(hm4_ff[31:0]) * 64'(hm4_ff[31:0]);
      hlh5_ff   <= 64'(hm4_ff[31:0]) * 64'(hm4_ff[63:32]);
      hhh5_ff   <= 64'(hm4_ff[63:32]) * 64'(hm4_ff[63:32]);
      all5_ff   <= 64'(a4_ff[31:0]) * 64'(cm4_ff[31:0]);
      alh5_ff   <= 64'(a4_ff[31:0]) * 64'(cm4_ff[63:32]);
      ahl5_ff   <= 64'(a4_ff[63:32]) * 64'(cm4_ff[31:0]);
      ahh5_ff   <= 64'(a4_ff[63:32]) * 64'(cm4_ff[63:32]);
      a5_ff     <= a4_ff;
      cneg5_ff  <= cneg4_ff;
      azero5_ff <= azero4_ff;
      h5_ff     <= h4_ff;
      oy5_ff    <= oy4_ff;
      dy5_ff    <= dy4_ff;
      tmax5_ff  <= tmax4_ff;

      hsq6_ff   <= {hhh5_ff, 64'd0} + (128'(hlh5_ff) << 33) + 128'(hll5_ff);
      ac6_ff    <= {ahh5_ff, 64'd0} + (128'(alh5_ff) << 32) + (128'(ahl5_ff) << 32)
                   + 128'(all5_ff);
      a6_ff     <= a5_ff;
      cneg6_ff  <= cneg5_ff;
      azero6_ff <= azero5_ff;
      h6_ff     <= h5_ff;
      oy6_ff    <= oy5_ff;
      dy6_ff    <= dy5_ff;
      tmax6_ff  <= tmax5_ff;

      d7_ff     <= cneg6_ff ? (hsq6_ff + ac6_ff) : (hsq6_ff - ac6_ff);
      a7_ff     <= a6_ff;
      azero7_ff <= azero6_ff;
      h7_ff     <= h6_ff;
      oy7_ff    <= oy6_ff;
      dy7_ff    <= dy6_ff;
      tmax7_ff  <= tmax6_ff;
   end

   always_comb begin
      sq_in_side.miss = azero7_ff | d7_ff[127];
      sq_in_side.h    = h7_ff;
      sq_in_side.a    = a7_ff;
      sq_in_side.oy   = oy7_ff;
      sq_in_side.dy   = dy7_ff;
      sq_in_side.tmax = tmax7_ff;
   end

   rcc_sqrt #(
      .SW($bits(sq_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_rad    (d7_ff),
      .in_side   (sq_in_side),
      .out_valid (sq_out_valid),
      .out_root  (sq_root),
      .out_side  (sq_out_side)
   );

   // stage 8
   always_comb begin
      hx_in  = {{2{sq_out_side.h[64]}}, sq_out_side.h};
      sx_in  = $signed({3'b000, sq_root});
      oyx_in = {{2{sq_out_side.oy[31]}}, sq_out_side.oy};
   end

   always_ff @(posedge clock) begin
      n0_8_ff  <= -hx_in - sx_in;
      n1_8_ff  <= sx_in - hx_in;
      c0_8_ff  <= -oyx_in;
      c1_8_ff  <= CAP_ONE - oyx_in;
      a8_ff    <= sq_out_side.a;
      miss8_ff <= sq_out_side.miss;
      oy8_ff   <= sq_out_side.oy;
      dy8_ff   <= sq_out_side.dy;
      tmax8_ff <= sq_out_side.tmax;
   end

   // stage 9
   always_comb begin
      n0m_in = n0_8_ff[66] ? 67'(-n0_8_ff) : n0_8_ff;
      n1m_in = n1_8_ff[66] ? 67'(-n1_8_ff) : n1_8_ff;
      c0m_in = c0_8_ff[33] ? 34'(-c0_8_ff) : c0_8_ff;
      c1m_in = c1_8_ff[33] ? 34'(-c1_8_ff) : c1_8_ff;
      dym_in = dy8_ff[31] ? 32'(-dy8_ff) : dy8_ff;
   end

   always_ff @(posedge clock) begin
      num9_ff[0]     <= {n0m_in[64:0], {FRAC_BITS{1'b0}}};
      num9_ff[1]     <= {n1m_in[64:0], {FRAC_BITS{1'b0}}};
      num9_ff[2]     <= {33'd0, c0m_in[31:0], {FRAC_BITS{1'b0}}};
      num9_ff[3]     <= {33'd0, c1m_in[31:0], {FRAC_BITS{1'b0}}};
      den9_ff[0]     <= a8_ff;
      den9_ff[1]     <= a8_ff;
      den9_ff[2]     <= {32'd0, dym_in};
      den9_ff[3]     <= {32'd0, dym_in};
      side9_ff.miss  <= miss8_ff;
      side9_ff.dyz   <= (dy8_ff == 32'sd0);
      side9_ff.oy    <= oy8_ff;
      side9_ff.dy    <= dy8_ff;
      side9_ff.tmax  <= tmax8_ff;
      side9_ff.neg0  <= n0_8_ff[66];
      side9_ff.neg1  <= n1_8_ff[66];
      side9_ff.cneg0 <= c0_8_ff[33] ^ dy8_ff[31];
      side9_ff.cneg1 <= c1_8_ff[33] ^ dy8_ff[31];
   end

   rcc_div #(
      .LANES (4),
      .NW    (NW),
      .DW    (64),
      .SW    ($bits(dv_side_type))
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v9_ff),
      .in_num     (num9_ff),
      .in_den     (den9_ff),
      .in_side    (side9_ff),
      .out_valid  (dv_out_valid),
      .out_quot   (dv_quot),
      .out_rem_nz (dv_nz),
      .out_side   (dv_out_side)
   );

   // stage 10: floor for wall roots, truncation for cap planes
   always_ff @(posedge clock) begin
      t0_10_ff  <= dv_out_side.neg0 ? $signed(~{1'b0, dv_quot[0]} + TW'(!dv_nz[0]))
                                    : $signed({1'b0, dv_quot[0]});
      t1_10_ff  <= dv_out_side.neg1 ? $signed(~{1'b0, dv_quot[1]} + TW'(!dv_nz[1]))
                                    : $signed({1'b0, dv_quot[1]});
      tc0_10_ff <= dv_out_side.cneg0 ? -$signed({1'b0, dv_quot[2]})
                                     : $signed({1'b0, dv_quot[2]});
      tc1_10_ff <= dv_out_side.cneg1 ? -$signed({1'b0, dv_quot[3]})
                                     : $signed({1'b0, dv_quot[3]});
      miss10_ff <= dv_out_side.miss;
      dyz10_ff  <= dv_out_side.dyz;
      oy10_ff   <= dv_out_side.oy;
      dy10_ff   <= dv_out_side.dy;
      tmax10_ff <= dv_out_side.tmax;
   end

   // stage 11: t * dy in 32-bit slices
   assign t0x_in = {{(TXW-TW){t0_10_ff[TW-1]}}, t0_10_ff};
   assign t1x_in = {{(TXW-TW){t1_10_ff[TW-1]}}, t1_10_ff};

   for (genvar k = 0; k < NCH; k++) begin : g_slice
      if (k == NCH - 1) begin : g_top
         always_ff @(posedge clock) begin
            pr0_11_ff[k] <= 65'($signed(t0x_in[32*k +: 32])) * 65'(dy10_ff);
            pr1_11_ff[k] <= 65'($signed(t1x_in[32*k +: 32])) * 65'(dy10_ff);
         end
      end else begin : g_low
         always_ff @(posedge clock) begin
            pr0_11_ff[k] <= 65'($signed({1'b0, t0x_in[32*k +: 32]})) * 65'(dy10_ff);
            pr1_11_ff[k] <= 65'($signed({1'b0, t1x_in[32*k +: 32]})) * 65'(dy10_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      t0_11_ff  <= t0_10_ff;
      tc0_11_ff <= tc0_10_ff;
      tc1_11_ff <= tc1_10_ff;
      miss11_ff <= miss10_ff;
      dyz11_ff  <= dyz10_ff;
      oy11_ff   <= oy10_ff;
      tmax11_ff <= tmax10_ff;
   end

   // stage 12: heights at scale 2^2F
   always_comb begin
      y0_in = $signed({{(YW-32){oy11_ff[31]}}, oy11_ff}) <<< FRAC_BITS;
      y1_in = y0_in;
      for (int k = 0; k < NCH; k++) begin
         y0_in = y0_in + ($signed({{(YW-65){pr0_11_ff[k][64]}}, pr0_11_ff[k]}) <<< (32 * k));
         y1_in = y1_in + ($signed({{(YW-65){pr1_11_ff[k][64]}}, pr1_11_ff[k]}) <<< (32 * k));
      end
   end

   always_ff @(posedge clock) begin
      y0_12_ff  <= y0_in;
      y1_12_ff  <= y1_in;
      t0_12_ff  <= t0_11_ff;
      tc0_12_ff <= tc0_11_ff;
      tc1_12_ff <= tc1_11_ff;
      miss12_ff <= miss11_ff;
      dyz12_ff  <= dyz11_ff;
      tmax12_ff <= tmax11_ff;
   end

   // classification
   always_comb begin
      tmaxx   = $signed({{(TW-31){1'b0}}, tmax12_ff});
      t0_ok   = (t0_12_ff > 0) && (t0_12_ff <= tmaxx);
      tc0_ok  = (tc0_12_ff > 0) && (tc0_12_ff <= tmaxx) && !dyz12_ff;
      tc1_ok  = (tc1_12_ff > 0) && (tc1_12_ff <= tmaxx) && !dyz12_ff;
      hit_in  = 1'b0;
      dist_in = '0;
      part_in = PART_BOTTOM;
      if (!miss12_ff) begin
         if (y0_12_ff[YW-1]) begin
            if (!y1_12_ff[YW-1] && tc0_ok) begin
               hit_in  = 1'b1;
               dist_in = tc0_12_ff[30:0];
               part_in = PART_BOTTOM;
            end
         end else if (y0_12_ff <= ONE_Y) begin
            if (t0_ok) begin
               hit_in  = 1'b1;
               dist_in = t0_12_ff[30:0];
               part_in = PART_SIDE;
            end
         end else begin
            if (!(y1_12_ff > ONE_Y) && tc1_ok) begin
               hit_in  = 1'b1;
               dist_in = tc1_12_ff[30:0];
               part_in = PART_TOP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= hit_in;
      rsp_dist_ff <= dist_in;
      rsp_part_ff <= part_in;
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_hit_dist = rsp_dist_ff;
   assign rsp_part     = rsp_part_ff;

endmodule

// ===== rtl/rcc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
module rcc_sqrt #(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [127:0]  in_rad,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [63:0]   out_root,
   output logic [SW-1:0] out_side
);

   localparam int STEPS = 64;
   localparam int REM_W = 67;

   logic [127:0]      rad_ff  [STEPS];
   logic [REM_W-1:0]  rem_ff  [STEPS];
   logic [63:0]       root_ff [STEPS];
   logic [SW-1:0]     side_ff [STEPS];
   logic              vld_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [127:0]     rad_src;
      logic [REM_W-1:0] rem_src;
      logic [63:0]      root_src;
      logic [SW-1:0]    side_src;
      logic             vld_src;
      logic [REM_W-1:0] acc;
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] rem_in;
      logic [63:0]      root_in;

      if (k == 0) begin : g_head
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_body
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      always_comb begin
         acc   = {rem_src[REM_W-3:0], rad_src[127:126]};
         trial = {1'b0, root_src, 2'b01};
         if (acc >= trial) begin
            rem_in  = acc - trial;
            root_in = {root_src[62:0], 1'b1};
         end else begin
            rem_in  = acc;
            root_in = {root_src[62:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k]  <= {rad_src[125:0], 2'b00};
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== rtl/rcc_div.sv =====
// Pipelined multi-lane unsigned restoring divider, one quotient bit per stage.
module rcc_div #(
   parameter int LANES = 4,
   parameter int NW    = 81,
   parameter int DW    = 64,
   parameter int SW    = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [LANES-1:0][NW-1:0]     in_num,
   input  logic [LANES-1:0][DW-1:0]     in_den,
   input  logic [SW-1:0]                in_side,
   output logic                         out_valid,
   output logic [LANES-1:0][NW-1:0]     out_quot,
   output logic [LANES-1:0]             out_rem_nz,
   output logic [SW-1:0]                out_side
);

   logic [LANES-1:0][NW-1:0] num_ff  [NW];
   logic [LANES-1:0][NW-1:0] quot_ff [NW];
   logic [LANES-1:0][DW-1:0] den_ff  [NW];
   logic [LANES-1:0][DW-1:0] rem_ff  [NW];
   logic [SW-1:0]            side_ff [NW];
   logic                     vld_ff  [NW];

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [LANES-1:0][NW-1:0] num_src;
      logic [LANES-1:0][NW-1:0] quot_src;
      logic [LANES-1:0][DW-1:0] den_src;
      logic [LANES-1:0][DW-1:0] rem_src;
      logic [SW-1:0]            side_src;
      logic                     vld_src;
      logic [LANES-1:0][DW:0]   acc;
      logic [LANES-1:0][NW-1:0] num_in;
      logic [LANES-1:0][NW-1:0] quot_in;
      logic [LANES-1:0][DW-1:0] rem_in;

      if (k == 0) begin : g_head
         assign num_src  = in_num;
         assign quot_src = '0;
         assign den_src  = in_den;
         assign rem_src  = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_body
         assign num_src  = num_ff[k-1];
         assign quot_src = quot_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            acc[l]    = {rem_src[l], num_src[l][NW-1]};
            num_in[l] = {num_src[l][NW-2:0], 1'b0};
            if (acc[l] >= {1'b0, den_src[l]}) begin
               rem_in[l]  = DW'(acc[l] - {1'b0, den_src[l]});
               quot_in[l] = {quot_src[l][NW-2:0], 1'b1};
            end else begin
               rem_in[l]  = acc[l][DW-1:0];
               quot_in[l] = {quot_src[l][NW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         num_ff[k]  <= num_in;
         quot_ff[k] <= quot_in;
         den_ff[k]  <= den_src;
         rem_ff[k]  <= rem_in;
         side_ff[k] <= side_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_rem_nz[l] = |rem_ff[NW-1][l];
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quot  = quot_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

// ===== rtl/rcc_checker.sv =====
// Port-level checks for the capped cylinder core, bound to the top level.
module rcc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic                        rsp_hit,
   input logic [rcc_pkg::DIST_W-1:0]  rsp_hit_dist,
   input rcc_pkg::part_type           rsp_part
);

   import rcc_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> busy && !rsp_valid)
      else $error("response or ready state survived reset");

   a_ready_after_reset: assert property (@(posedge clock) !reset |=> !busy)
      else $error("busy without reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_dist == '0 && rsp_part == PART_BOTTOM)
      else $error("miss response carries nonzero fields");

   a_hit_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_hit_dist != '0)
      else $error("hit at zero distance");

endmodule

bind ray_capped_cylinder_intersect_core rcc_checker u_rcc_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_hit      (rsp_hit),
   .rsp_hit_dist (rsp_hit_dist),
   .rsp_part     (rsp_part)
);
